// ===== design/bcdrtc_pkg.sv =====
// Shared types, register map and BCD helper functions for the BCD clock/calendar core.
package bcdrtc_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_PTR   = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	// register map
	localparam int REG_SEC      = 'h00;
	localparam int REG_MIN      = 'h01;
	localparam int REG_HOUR     = 'h02;
	localparam int REG_WDAY     = 'h03;
	localparam int REG_DATE     = 'h04;
	localparam int REG_MONTH    = 'h05;
	localparam int REG_YEAR     = 'h06;
	localparam int REG_TEMP_MSB = 'h11;
	localparam int REG_TEMP_LSB = 'h12;

	localparam int TPS_W = 20;
	localparam logic [TPS_W-1:0] TPS_RESET = 20'd1000000;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 16;
	localparam int TEMP_W      = 13;

	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -13'sd512;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 13'sd511;

	localparam logic [7:0] HOUR_12H_BIT = 8'h40;
	localparam logic [7:0] HOUR_PM_BIT  = 8'h20;

	// binary value of a byte whose nibbles are taken as decimal digits (0..165)
	function automatic logic [7:0] bcd_val(input logic [7:0] b);
		return 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0}) + 8'(b[3:0]);
	endfunction

	// two-digit BCD of a value below 100
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [3:0] tens;
		logic [6:0] ones;
		tens = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if (v >= 7'(10 * k)) begin
				tens = 4'(k);
			end
		end
		ones = v - 7'(tens) * 7'd10;
		return {tens, ones[3:0]};
	endfunction

	// month length; months outside 1..12 count as 31 days
	function automatic logic [4:0] days_in_month(input logic [7:0] m, input logic [7:0] y,
		input logic century);
		logic [4:0] dim;
		case (m) inside
			8'd4, 8'd6, 8'd9, 8'd11: dim = 5'd30;
			8'd2: dim = (y[1:0] == 2'b00 && !(y == 8'd0 && century)) ? 5'd29 : 5'd28;
			default: dim = 5'd31;
		endcase
		return dim;
	endfunction

endpackage

// ===== design/bcd_rtc_calendar_registers_core.sv =====
// BCD real-time clock and calendar core with a byte-wide register file.
//
//  channel | signals                                  | content
//  --------+------------------------------------------+-------------------------------------
//  in      | s_axis_tvalid/tready/tdata/tuser         | opcode, data byte, temperature sample
//  out     | m_axis_tvalid/tready/tdata               | read byte, second rolled flag
//  cfg     | cfg_we/cfg_wdata                         | ticks per second
//
// One word in, one word out, one word taken per cycle while the output is not stalled.
// The input stage feeds the whole cascade (sec -> min -> hour -> weekday/date/month/year),
// which settles into the output register; m_axis_tvalid rises as the word moves there.
// s_axis_tready drops only when the input stage and the output register are both full
// and m_axis_tready is low; an output stall backs up through the single input stage.
// Reset (arst_n, async) clears registers, pointer and prescaler; ticks per second = 1000000.
module bcd_rtc_calendar_registers_core
	import bcdrtc_pkg::*;
#(
	parameter int NUM_REGS = 19
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // [7:0] data, [20:8] temperature_quarters
	input  logic [1:0]              s_axis_tuser,   // [1:0] opcode
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // [7:0] read_data, [8] second_rolled
	input  logic                    cfg_we,
	input  logic [TPS_W-1:0]        cfg_wdata
);

	localparam int PTR_W = $clog2(NUM_REGS);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(NUM_REGS - 1);

	// ---------------- state ----------------
	logic [7:0]        regs_q [NUM_REGS];
	logic [PTR_W-1:0]  ptr_q;
	logic [TPS_W-1:0]  presc_q;
	logic [TPS_W-1:0]  tps_q;

	// input stage
	logic                     valid_s1;
	op_t                      op_s1;
	logic [7:0]               data_s1;
	logic signed [TEMP_W-1:0] temp_s1;

	// output stage
	logic       valid_s2;
	logic [7:0] rdata_s2;
	logic       rolled_s2;

	logic proc;  // input stage word moves into the output register this cycle

	assign proc          = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= op_t'(s_axis_tuser);
			data_s1 <= s_axis_tdata[7:0];
			temp_s1 <= s_axis_tdata[20:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (cfg_we) begin
			tps_q <= cfg_wdata;
		end
	end

	// ---------------- pointer ----------------
	// pointer load is data mod NUM_REGS: a constant table over all byte values
	logic [PTR_W-1:0] ptr_mod [256];
	for (genvar g = 0; g < 256; g++) begin : g_ptr_mod
		localparam logic [PTR_W-1:0] ModVal = PTR_W'(g % NUM_REGS);
		assign ptr_mod[g] = ModVal;
	end

	logic [PTR_W-1:0] ptr_inc;
	assign ptr_inc = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;

	// ---------------- prescaler ----------------
	logic [TPS_W-1:0] presc_inc;
	logic             roll;
	assign presc_inc = presc_q + 1'b1;
	assign roll      = (presc_inc >= tps_q);  // zero ticks per second rolls every tick

	// ---------------- temperature ----------------
	logic [9:0] temp_sat;
	always_comb begin
		if (temp_s1 < TEMP_MIN) begin
			temp_sat = 10'h200;
		end else if (temp_s1 > TEMP_MAX) begin
			temp_sat = 10'h1FF;
		end else begin
			temp_sat = temp_s1[9:0];
		end
	end

	// ---------------- time cascade ----------------
	logic [7:0] r_sec, r_min, r_hour, r_wday, r_date, r_month, r_year;
	assign r_sec   = regs_q[PTR_W'(REG_SEC)];
	assign r_min   = regs_q[PTR_W'(REG_MIN)];
	assign r_hour  = regs_q[PTR_W'(REG_HOUR)];
	assign r_wday  = regs_q[PTR_W'(REG_WDAY)];
	assign r_date  = regs_q[PTR_W'(REG_DATE)];
	assign r_month = regs_q[PTR_W'(REG_MONTH)];
	assign r_year  = regs_q[PTR_W'(REG_YEAR)];

	logic [7:0] sec_v, min_v;
	logic       sec_carry, min_carry, hour_carry;
	logic [7:0] sec_nx, min_nx, hour_nx, wday_nx, date_nx, month_nx, year_nx;

	logic       mode12;
	logic [7:0] h12_raw, h12_mod, h_cur;
	logic [4:0] h_next, h12_out;

	logic       century, century_nx;
	logic [7:0] d_v, m_v, y_v, m_next, y_next;
	logic [4:0] dim;

	always_comb begin
		sec_v     = bcd_val({1'b0, r_sec[6:0]}) + 8'd1;
		sec_carry = (sec_v >= 8'd60);
		sec_nx    = sec_carry ? 8'h00 : to_bcd(sec_v[6:0]);

		min_v     = bcd_val({1'b0, r_min[6:0]}) + 8'd1;
		min_carry = sec_carry && (min_v >= 8'd60);
		min_nx    = !sec_carry ? r_min : (min_carry ? 8'h00 : to_bcd(min_v[6:0]));

		// hour in 0..23 terms; 12-hour mode maps 12 AM to 0 and 12 PM to 12
		mode12  = r_hour[6];
		h12_raw = bcd_val({3'b000, r_hour[4:0]});
		if (h12_raw >= 8'd24) begin
			h12_mod = h12_raw - 8'd24;
		end else if (h12_raw >= 8'd12) begin
			h12_mod = h12_raw - 8'd12;
		end else begin
			h12_mod = h12_raw;
		end
		h_cur = mode12 ? h12_mod + (r_hour[5] ? 8'd12 : 8'd0)
		               : bcd_val({2'b00, r_hour[5:0]});
		hour_carry = min_carry && (h_cur >= 8'd23);
		h_next     = (h_cur >= 8'd23) ? 5'd0 : 5'(h_cur + 8'd1);
		h12_out    = (h_next >= 5'd12) ? h_next - 5'd12 : h_next;
		if (h12_out == 5'd0) begin
			h12_out = 5'd12;
		end
		if (!min_carry) begin
			hour_nx = r_hour;
		end else if (mode12) begin
			hour_nx = to_bcd(7'(h12_out)) | HOUR_12H_BIT
			        | ((h_next >= 5'd12) ? HOUR_PM_BIT : 8'h00);
		end else begin
			hour_nx = to_bcd(7'(h_next));
		end

		// day, month, year
		century = r_month[7];
		d_v     = bcd_val({2'b00, r_date[5:0]});
		m_v     = bcd_val({3'b000, r_month[4:0]});
		y_v     = bcd_val(r_year);
		dim     = days_in_month(m_v, y_v, century);

		wday_nx    = r_wday;
		date_nx    = r_date;
		month_nx   = r_month;
		year_nx    = r_year;
		m_next     = m_v;
		y_next     = y_v;
		century_nx = century;
		if (hour_carry) begin
			wday_nx = (r_wday >= 8'd7 || r_wday == 8'd0) ? 8'd1 : r_wday + 8'd1;
			if (d_v != 8'd0 && d_v < 8'(dim)) begin
				date_nx = to_bcd(7'(d_v + 8'd1));
			end else begin
				date_nx = 8'h01;
				if (m_v >= 8'd12) begin
					m_next = 8'd1;
					if (y_v >= 8'd99) begin
						y_next     = 8'd0;
						century_nx = !century;
					end else begin
						y_next = y_v + 8'd1;
					end
					year_nx = to_bcd(y_next[6:0]);
				end else begin
					m_next = m_v + 8'd1;
				end
				month_nx = to_bcd(m_next[6:0]) | {century_nx, 7'b0};
			end
		end
	end

	// ---------------- state update ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= 8'h00;
			end
			ptr_q   <= '0;
			presc_q <= '0;
		end else if (proc) begin
			unique case (op_s1)
				OP_TICK: begin
					regs_q[PTR_W'(REG_TEMP_MSB)] <= temp_sat[9:2];
					regs_q[PTR_W'(REG_TEMP_LSB)] <= {temp_sat[1:0], 6'b0};
					if (roll) begin
						presc_q                   <= '0;
						regs_q[PTR_W'(REG_SEC)]   <= sec_nx;
						regs_q[PTR_W'(REG_MIN)]   <= min_nx;
						regs_q[PTR_W'(REG_HOUR)]  <= hour_nx;
						regs_q[PTR_W'(REG_WDAY)]  <= wday_nx;
						regs_q[PTR_W'(REG_DATE)]  <= date_nx;
						regs_q[PTR_W'(REG_MONTH)] <= month_nx;
						regs_q[PTR_W'(REG_YEAR)]  <= year_nx;
					end else begin
						presc_q <= presc_inc;
					end
				end
				OP_PTR: begin
					ptr_q <= ptr_mod[data_s1];
				end
				OP_WRITE: begin
					regs_q[ptr_q] <= data_s1;
					if (ptr_q == PTR_W'(REG_SEC)) begin
						presc_q <= '0;  // seconds write restarts the second
					end
					ptr_q <= ptr_inc;
				end
				OP_READ: begin
					ptr_q <= ptr_inc;
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (proc) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			rdata_s2  <= (op_s1 == OP_READ) ? regs_q[ptr_q] : 8'h00;
			rolled_s2 <= (op_s1 == OP_TICK) && roll;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'b0, rolled_s2, rdata_s2};

`ifndef ASSERT_OFF
	// pointer never leaves the register file
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= PTR_LAST)
		else $error("register pointer out of range");

	// a rolled second comes only from a tick, which returns no read byte
	a_roll_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rolled_s2 |-> rdata_s2 == 8'h00)
		else $error("rolled second carries read data");

	// a rolling tick restarts the prescaler
	a_roll_clears: assert property (@(posedge clk) disable iff (!arst_n)
		proc && op_s1 == OP_TICK && roll |=> presc_q == '0)
		else $error("prescaler not cleared on second roll");

	// an empty output register never blocks the input side
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_axis_tready)
		else $error("input stalled with output register empty");
`endif

endmodule
